// File: rtl/core/twhl_pkg.sv
`default_nettype none

package twhl_pkg;

    // Configuration register widths and indexes
    localparam int TIMEOUT_W   = 24;
    localparam int GAP_W       = 16;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP     = 1'b1;

    // Wait timer; at least as wide as the timeout register
    localparam int TIMER_WIDTH = 24;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd1000000;
    localparam logic [GAP_W-1:0]     GAP_RESET     = 16'd0;

    // Bits per byte
    localparam int          BYTE_W      = 8;
    localparam int          COUNT_W     = 4;
    localparam logic [COUNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // Request codes
    localparam logic [1:0] REQ_TX = 2'd1;
    localparam logic [1:0] REQ_RX = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TX_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_RX_TIMEOUT = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TX_LOW,
        PH_TX_HIGH,
        PH_TX_GAP,
        PH_RX_START,
        PH_RX_REL,
        PH_RX_GAP
    } phase_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [BYTE_W-1:0] tx_byte;
        logic              red_in;
        logic              white_in;
    } in_beat_t;

    typedef struct packed {
        logic              red_drive;
        logic              white_drive;
        logic              busy_res;
        logic              done_res;
        logic [1:0]        status_code;
        logic [BYTE_W-1:0] rx_byte;
        logic              line_active;
    } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/core/two_wire_handshake_link.sv
`default_nettype none

// Two-wire (red/white) open-drain handshake link engine. Each input beat is
// one tick of the link: it carries the sampled wire levels and an optional
// command to send (LSB first) or receive one byte; every beat yields exactly
// one result beat with the wire drives, busy, a one-tick done pulse with its
// status, the last received byte and line activity. One beat is taken every
// clock cycle while out_stall is low: a beat lands in the input register,
// the engine state and the result are worked out from it combinationally,
// and the result sits in the output register. Commands arriving while busy
// are ignored; every handshake wait times out once its tick count reaches
// the timeout register and releases both wires. Write the configuration
// registers only while the link is idle.
module two_wire_handshake_link (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire twhl_pkg::in_beat_t                in_beat,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output twhl_pkg::out_beat_t                    out_beat,
    input  wire logic                              cfg_we,
    input  wire logic [twhl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [twhl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import twhl_pkg::*;

    // Configuration
    logic [TIMEOUT_W-1:0]   timeout_reg;
    logic [GAP_W-1:0]       gap_reg;

    // Pipeline
    logic                   in_valid_reg;
    in_beat_t               in_beat_reg;
    logic                   out_valid_reg;
    out_beat_t              out_beat_reg;
    logic                   adv;

    // Engine state
    phase_t                 phase_reg,   phase_next;
    logic [BYTE_W-1:0]      shift_reg,   shift_next;
    logic [COUNT_W-1:0]     count_reg,   count_next;
    logic [TIMER_WIDTH-1:0] timer_reg,   timer_next;
    logic                   red_reg,     red_next;
    logic                   white_reg,   white_next;
    logic                   bit_reg,     bit_next;
    logic [BYTE_W-1:0]      rcv_reg,     rcv_next;
    logic                   done_next;
    logic [1:0]             status_next;
    out_beat_t              result;

    // Helpers
    logic [TIMER_WIDTH-1:0] timer_inc;
    logic                   expired;
    logic                   gap_zero;
    logic                   watched;
    logic                   do_bit_done;
    logic                   do_proceed;
    logic                   proceed_tx;
    logic                   red_s;
    logic                   white_s;

    // Handshake: the input register advances when the output register frees
    assign adv       = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !adv;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    assign red_s     = in_beat_reg.red_in;
    assign white_s   = in_beat_reg.white_in;

    // Saturating wait timer and timeout compare (zero limit acts as one)
    assign timer_inc = (timer_reg == {TIMER_WIDTH{1'b1}}) ? timer_reg
                                                          : timer_reg + 1'b1;
    assign expired   = timer_inc >= TIMER_WIDTH'(timeout_reg);
    assign gap_zero  = (gap_reg == '0);
    assign watched   = bit_reg ? red_s : white_s;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            gap_reg     <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                CFG_GAP:     gap_reg     <= cfg_data[GAP_W-1:0];
                default:     ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_beat_reg <= in_beat;
        end
    end

    // Next engine state for the beat in the input register
    always_comb
    begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        timer_next  = timer_reg;
        red_next    = red_reg;
        white_next  = white_reg;
        bit_next    = bit_reg;
        rcv_next    = rcv_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        do_bit_done = 1'b0;
        do_proceed  = 1'b0;
        proceed_tx  = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_beat_reg.req_type == REQ_TX)
                begin
                    shift_next = in_beat_reg.tx_byte;
                    count_next = '0;
                    bit_next   = in_beat_reg.tx_byte[0];
                    red_next   = in_beat_reg.tx_byte[0];
                    white_next = !in_beat_reg.tx_byte[0];
                    timer_next = '0;
                    phase_next = PH_TX_LOW;
                end
                else if (in_beat_reg.req_type == REQ_RX)
                begin
                    shift_next = '0;
                    count_next = '0;
                    timer_next = '0;
                    phase_next = PH_RX_START;
                end
            end
            PH_TX_LOW:
            begin
                if (!watched)
                begin
                    red_next   = 1'b1;
                    white_next = 1'b1;
                    timer_next = '0;
                    phase_next = PH_TX_HIGH;
                end
                else
                begin
                    timer_next = timer_inc;
                    if (expired)
                    begin
                        phase_next  = PH_IDLE;
                        red_next    = 1'b1;
                        white_next  = 1'b1;
                        timer_next  = '0;
                        done_next   = 1'b1;
                        status_next = ST_TX_TIMEOUT;
                    end
                end
            end
            PH_TX_HIGH:
            begin
                if (watched)
                begin
                    shift_next  = {1'b0, shift_reg[BYTE_W-1:1]};
                    do_bit_done = 1'b1;
                    proceed_tx  = 1'b1;
                end
                else
                begin
                    timer_next = timer_inc;
                    if (expired)
                    begin
                        phase_next  = PH_IDLE;
                        red_next    = 1'b1;
                        white_next  = 1'b1;
                        timer_next  = '0;
                        done_next   = 1'b1;
                        status_next = ST_TX_TIMEOUT;
                    end
                end
            end
            PH_RX_START:
            begin
                if (red_s && white_s)
                begin
                    timer_next = timer_inc;
                    if (expired)
                    begin
                        phase_next  = PH_IDLE;
                        red_next    = 1'b1;
                        white_next  = 1'b1;
                        timer_next  = '0;
                        done_next   = 1'b1;
                        status_next = ST_RX_TIMEOUT;
                    end
                end
                else
                begin
                    // Red high with white low is a one, acked on red
                    if (red_s && !white_s)
                    begin
                        bit_next   = 1'b1;
                        shift_next = {1'b1, shift_reg[BYTE_W-1:1]};
                        red_next   = 1'b0;
                    end
                    else
                    begin
                        bit_next   = 1'b0;
                        shift_next = {1'b0, shift_reg[BYTE_W-1:1]};
                        white_next = 1'b0;
                    end
                    timer_next = '0;
                    phase_next = PH_RX_REL;
                end
            end
            PH_RX_REL:
            begin
                if (bit_reg ? white_s : red_s)
                begin
                    do_bit_done = 1'b1;
                end
                else
                begin
                    timer_next = timer_inc;
                    if (expired)
                    begin
                        phase_next  = PH_IDLE;
                        red_next    = 1'b1;
                        white_next  = 1'b1;
                        timer_next  = '0;
                        done_next   = 1'b1;
                        status_next = ST_RX_TIMEOUT;
                    end
                end
            end
            PH_TX_GAP, PH_RX_GAP:
            begin
                timer_next = timer_inc;
                proceed_tx = (phase_reg == PH_TX_GAP);
                do_proceed = (timer_inc >= TIMER_WIDTH'(gap_reg));
            end
            default:
            begin
                phase_next = PH_IDLE;
                red_next   = 1'b1;
                white_next = 1'b1;
                timer_next = '0;
            end
        endcase

        // End of a bit: release both wires, then gap or go straight on
        if (do_bit_done)
        begin
            red_next   = 1'b1;
            white_next = 1'b1;
            count_next = count_reg + 1'b1;
            timer_next = '0;
            if (gap_zero)
            begin
                do_proceed = 1'b1;
            end
            else
            begin
                phase_next = proceed_tx ? PH_TX_GAP : PH_RX_GAP;
            end
        end

        // Next bit or end of byte
        if (do_proceed)
        begin
            if (count_next >= BITS_PER_BYTE)
            begin
                if (!proceed_tx)
                begin
                    rcv_next = shift_next;
                end
                phase_next  = PH_IDLE;
                red_next    = 1'b1;
                white_next  = 1'b1;
                timer_next  = '0;
                done_next   = 1'b1;
                status_next = ST_OK;
            end
            else if (proceed_tx)
            begin
                bit_next   = shift_next[0];
                red_next   = shift_next[0];
                white_next = !shift_next[0];
                timer_next = '0;
                phase_next = PH_TX_LOW;
            end
            else
            begin
                timer_next = '0;
                phase_next = PH_RX_START;
            end
        end
    end

    // Result beat: state after this tick
    always_comb
    begin
        result.red_drive   = red_next;
        result.white_drive = white_next;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done_next;
        result.status_code = status_next;
        result.rx_byte     = rcv_next;
        result.line_active = !red_s || !white_s;
    end

    // Engine state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            count_reg <= '0;
            timer_reg <= '0;
            red_reg   <= 1'b1;
            white_reg <= 1'b1;
            bit_reg   <= 1'b0;
            rcv_reg   <= '0;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            timer_reg <= timer_next;
            red_reg   <= red_next;
            white_reg <= white_next;
            bit_reg   <= bit_next;
            rcv_reg   <= rcv_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_beat_reg <= result;
        end
    end

    // Checks
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_beat_reg.done_res |-> !out_beat_reg.busy_res)
        else $error("done reported while still busy");

    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_beat_reg.done_res |-> out_beat_reg.status_code == ST_OK)
        else $error("status set without done");

    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> red_reg && white_reg)
        else $error("wire driven low while idle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= BITS_PER_BYTE)
        else $error("bit count beyond one byte");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(phase_reg) && $stable(timer_reg))
        else $error("engine state moved without a beat");

endmodule

`default_nettype wire

// File: tb/handshake_link_check.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the link, keeps its own
// copy of the engine state and compares every result beat with the forecast.
module handshake_link_check
    import twhl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire in_beat_t               in_beat,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire out_beat_t              out_beat,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          mismatches,
    output int                          pending,
    output logic                        engine_busy
);

    // Forecast result beats, oldest first
    out_beat_t forecast_q[$];

    int   error_count = 0;
    int   pending_n   = 0;
    logic busy_n      = 1'b0;

    assign mismatches  = error_count;
    assign pending     = pending_n;
    assign engine_busy = busy_n;

    // Shadow registers and engine state
    logic [TIMEOUT_W-1:0]   timeout_cfg;
    logic [GAP_W-1:0]       gap_cfg;
    phase_t                 link_phase;
    logic [BYTE_W-1:0]      shreg;
    logic [COUNT_W-1:0]     bit_cnt;
    logic [TIMER_WIDTH-1:0] wait_ticks;
    logic                   red_q;
    logic                   white_q;
    logic                   cur_bit;
    logic [BYTE_W-1:0]      rx_hold;
    logic                   done_now;
    logic [1:0]             status_now;

    task report(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task check_field(input string what, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    task clear_engine();
        timeout_cfg = TIMEOUT_RESET;
        gap_cfg     = GAP_RESET;
        link_phase  = PH_IDLE;
        shreg       = '0;
        bit_cnt     = '0;
        wait_ticks  = '0;
        red_q       = 1'b1;
        white_q     = 1'b1;
        cur_bit     = 1'b0;
        rx_hold     = '0;
    endtask

    // Saturating wait timer
    task bump_timer();
        if (wait_ticks != '1)
            wait_ticks++;
    endtask

    // One failing wait tick; zero timeout behaves as one
    task count_wait(output logic expired);
        bump_timer();
        expired = (wait_ticks >= timeout_cfg);
    endtask

    task end_transfer(input logic [1:0] code);
        red_q      = 1'b1;
        white_q    = 1'b1;
        link_phase = PH_IDLE;
        wait_ticks = '0;
        done_now   = 1'b1;
        status_now = code;
    endtask

    // Drive the first half of a sent bit: 1 pulls white, 0 pulls red
    task launch_bit();
        cur_bit    = shreg[0];
        red_q      = shreg[0];
        white_q    = ~shreg[0];
        wait_ticks = '0;
        link_phase = PH_TX_LOW;
    endtask

    // After a bit and its gap: next bit, or the end of the byte
    task next_step(input logic tx);
        if (bit_cnt >= BITS_PER_BYTE) begin
            if (!tx)
                rx_hold = shreg;
            end_transfer(ST_OK);
        end
        else if (tx) begin
            launch_bit();
        end
        else begin
            wait_ticks = '0;
            link_phase = PH_RX_START;
        end
    endtask

    task close_bit(input logic tx);
        red_q      = 1'b1;
        white_q    = 1'b1;
        bit_cnt    = bit_cnt + 1'b1;
        wait_ticks = '0;
        if (gap_cfg == '0)
            next_step(tx);
        else
            link_phase = tx ? PH_TX_GAP : PH_RX_GAP;
    endtask

    // One tick of the engine; returns the result beat it yields
    task advance_link(input in_beat_t b, output out_beat_t r);
        logic expired;
        logic seen;
        done_now   = 1'b0;
        status_now = ST_OK;
        case (link_phase)
            PH_IDLE:
            begin
                if (b.req_type == REQ_TX) begin
                    shreg   = b.tx_byte;
                    bit_cnt = '0;
                    launch_bit();
                end
                else if (b.req_type == REQ_RX) begin
                    shreg      = '0;
                    bit_cnt    = '0;
                    wait_ticks = '0;
                    link_phase = PH_RX_START;
                end
            end
            PH_TX_LOW:
            begin
                seen = cur_bit ? b.red_in : b.white_in;
                if (!seen) begin
                    red_q      = 1'b1;
                    white_q    = 1'b1;
                    wait_ticks = '0;
                    link_phase = PH_TX_HIGH;
                end
                else begin
                    count_wait(expired);
                    if (expired)
                        end_transfer(ST_TX_TIMEOUT);
                end
            end
            PH_TX_HIGH:
            begin
                seen = cur_bit ? b.red_in : b.white_in;
                if (seen) begin
                    shreg = {1'b0, shreg[BYTE_W-1:1]};
                    close_bit(1'b1);
                end
                else begin
                    count_wait(expired);
                    if (expired)
                        end_transfer(ST_TX_TIMEOUT);
                end
            end
            PH_RX_START:
            begin
                if (b.red_in && b.white_in) begin
                    count_wait(expired);
                    if (expired)
                        end_transfer(ST_RX_TIMEOUT);
                end
                else begin
                    // red high, white low is a 1; any other low pattern a 0
                    if (b.red_in && !b.white_in) begin
                        cur_bit = 1'b1;
                        shreg   = {1'b1, shreg[BYTE_W-1:1]};
                        red_q   = 1'b0;
                    end
                    else begin
                        cur_bit = 1'b0;
                        shreg   = {1'b0, shreg[BYTE_W-1:1]};
                        white_q = 1'b0;
                    end
                    wait_ticks = '0;
                    link_phase = PH_RX_REL;
                end
            end
            PH_RX_REL:
            begin
                seen = cur_bit ? b.white_in : b.red_in;
                if (seen) begin
                    close_bit(1'b0);
                end
                else begin
                    count_wait(expired);
                    if (expired)
                        end_transfer(ST_RX_TIMEOUT);
                end
            end
            PH_TX_GAP, PH_RX_GAP:
            begin
                bump_timer();
                if (wait_ticks >= gap_cfg)
                    next_step(link_phase == PH_TX_GAP);
            end
            default:
            begin
                end_transfer(ST_OK);
                done_now = 1'b0;
            end
        endcase
        r.red_drive   = red_q;
        r.white_drive = white_q;
        r.busy_res    = (link_phase != PH_IDLE);
        r.done_res    = done_now;
        r.status_code = status_now;
        r.rx_byte     = rx_hold;
        r.line_active = !b.red_in || !b.white_in;
    endtask

    // Compare leaving beats, then shadow register writes, then forecast new ones
    always @(posedge clk) begin
        out_beat_t want;
        out_beat_t fresh;
        if (!rst_n) begin
            clear_engine();
            forecast_q.delete();
        end
        else begin
            if (out_valid && !out_stall) begin
                if (forecast_q.size() == 0) begin
                    report("result beat with nothing forecast", int'(out_beat), 0);
                end
                else begin
                    want = forecast_q.pop_front();
                    check_field("red_drive", out_beat.red_drive, want.red_drive);
                    check_field("white_drive", out_beat.white_drive, want.white_drive);
                    check_field("busy_res", out_beat.busy_res, want.busy_res);
                    check_field("done_res", out_beat.done_res, want.done_res);
                    check_field("status_code", out_beat.status_code, want.status_code);
                    check_field("rx_byte", out_beat.rx_byte, want.rx_byte);
                    check_field("line_active", out_beat.line_active, want.line_active);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TIMEOUT: timeout_cfg = cfg_data[TIMEOUT_W-1:0];
                    CFG_GAP:     gap_cfg     = cfg_data[GAP_W-1:0];
                    default:     ;
                endcase
            end
            if (in_valid && !in_stall) begin
                advance_link(in_beat, fresh);
                forecast_q.push_back(fresh);
            end
        end
        pending_n <= forecast_q.size();
        busy_n    <= (link_phase != PH_IDLE);
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import twhl_pkg::*;

    localparam logic [1:0]           REQ_TICK    = 2'd0;
    localparam logic [1:0]           REQ_UNKNOWN = 2'd3;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = '1;
    localparam logic [GAP_W-1:0]     GAP_LONG    = 16'd20;
    localparam int                   CYCLE_LIMIT = 1_000_000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_beat_t               in_beat   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_beat_t              out_beat;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   calm      = 1'b0;
    int                     mismatches;
    int                     pending;
    logic                   engine_busy;
    int                     cycle_count = 0;

    two_wire_handshake_link dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    handshake_link_check link_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_beat     (in_beat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_beat    (out_beat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending),
        .engine_busy (engine_busy)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 11);
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // One tick beat, with random idle cycles ahead of it
    task automatic send_tick(input logic [1:0] req, input logic [7:0] txb,
                             input logic red, input logic white);
        while (!calm && $urandom_range(99) < 11) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{req_type: req, tx_byte: txb, red_in: red, white_in: white};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Random wires with occasional released stretches that starve the waits
    task automatic random_ticks(input int count);
        int         hold;
        int         pick;
        logic [1:0] req;
        logic [7:0] txb;
        logic       red;
        logic       white;
        hold = 0;
        for (int i = 0; i < count; i++) begin
            if (hold == 0 && $urandom_range(99) < 4)
                hold = $urandom_range(20, 3);
            if (hold > 0) begin
                red   = 1'b1;
                white = 1'b1;
                hold--;
            end
            else begin
                red   = 1'($urandom_range(1));
                white = 1'($urandom_range(1));
            end
            pick = $urandom_range(99);
            if (pick < 70)
                req = REQ_TICK;
            else if (pick < 85)
                req = REQ_TX;
            else if (pick < 97)
                req = REQ_RX;
            else
                req = REQ_UNKNOWN;
            case ($urandom_range(9))
                0:       txb = 8'h00;
                1:       txb = 8'hFF;
                default: txb = 8'($urandom_range(255));
            endcase
            send_tick(req, txb, red, white);
        end
    endtask

    // Walk the engine back to idle, then let every result beat come out
    task automatic drain_link();
        logic lvl;
        lvl = 1'b0;
        do begin
            send_tick(REQ_TICK, 8'h00, lvl, lvl);
            lvl = ~lvl;
        end while (engine_busy);
        in_valid <= 1'b0;
        // The count seen here is registered and still lags the last accepted beat
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Both registers, back to back
    task automatic set_config(input logic [TIMEOUT_W-1:0] timeout,
                              input logic [GAP_W-1:0] gap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= CFG_DATA_W'(timeout);
        @(posedge clk);
        cfg_index <= CFG_GAP;
        cfg_data  <= CFG_DATA_W'(gap);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: line activity, unknown request, a full send of 0x00 with
        // commands arriving while busy
        send_tick(REQ_TICK, 8'h00, 1'b1, 1'b1);
        send_tick(REQ_TICK, 8'h00, 1'b0, 1'b0);
        send_tick(REQ_TICK, 8'h00, 1'b0, 1'b1);
        send_tick(REQ_TICK, 8'h00, 1'b1, 1'b0);
        send_tick(REQ_UNKNOWN, 8'hFF, 1'b1, 1'b1);
        send_tick(REQ_TX, 8'h00, 1'b1, 1'b1);
        for (int i = 0; i < 8; i++) begin
            send_tick((i == 0) ? REQ_RX : ((i == 3) ? REQ_TX : REQ_TICK), 8'hFF, 1'b0, 1'b0);
            send_tick(REQ_TICK, 8'h00, 1'b1, 1'b1);
        end
        drain_link();

        // Zero timeout behaves as one
        set_config('0, '0);
        random_ticks(50);
        drain_link();

        // Shortest timeout, shortest nonzero gap
        set_config(24'd1, 16'd1);
        random_ticks(50);
        drain_link();

        // Longest timeout: transfers run to completion
        set_config(TIMEOUT_MAX, '0);
        random_ticks(70);
        drain_link();

        // Long gap: one bit, the full gap, then a starved wait times out
        set_config(24'd5, GAP_LONG);
        send_tick(REQ_TX, 8'($urandom_range(255)), 1'b1, 1'b1);
        send_tick(REQ_TICK, 8'h00, 1'b0, 1'b0);
        send_tick(REQ_TICK, 8'h00, 1'b1, 1'b1);
        for (int i = 0; i < int'(GAP_LONG) + 16; i++)
            send_tick(REQ_TICK, 8'h00, 1'b1, 1'b1);
        drain_link();

        // Mid settings, with a stretch free of idling on both sides
        set_config(24'($urandom_range(12, 2)), 16'($urandom_range(4, 1)));
        random_ticks(60);
        calm <= 1'b1;
        random_ticks(90);
        calm <= 1'b0;
        random_ticks(60);
        drain_link();

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
